// ----- hdl/text_terminal_cell_writer_unit_defines.svh -----
// Assertion macros used by the checker file of this block.
`ifndef TEXT_TERMINAL_CELL_WRITER_UNIT_DEFINES_SVH
`define TEXT_TERMINAL_CELL_WRITER_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the trigger.
`define TTCW_CHECK_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("ttcw port check failed");

// The consequent must hold in the same cycle as the trigger.
`define TTCW_CHECK_NOW(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("ttcw port check failed");

`endif

// ----- hdl/ttcw_pkg.sv -----
package ttcw_pkg;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_CR           = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF           = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB          = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BS           = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE        = 8'd32;
    localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;
    localparam int                TAB_STOP        = 8;

    localparam logic CFG_NUM_COLUMNS = 1'b0;
    localparam logic CFG_NUM_ROWS    = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scroll;
        logic              wr_en;
        logic [COL_W-1:0]  wr_col;
        logic [ROW_W-1:0]  wr_row;
        logic [CHAR_W-1:0] wr_char;
    } put_act_t;

endpackage

// ----- hdl/ttcw_cell_ram.sv -----
module ttcw_cell_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [ttcw_pkg::CHAR_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [ttcw_pkg::CHAR_W-1:0] rdata
);
    import ttcw_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/ttcw_cursor_step.sv -----
module ttcw_cursor_step (
    input  logic [ttcw_pkg::COL_W-1:0]  cur_col,
    input  logic [ttcw_pkg::ROW_W-1:0]  cur_row,
    input  logic [ttcw_pkg::COL_W-1:0]  cols,
    input  logic [ttcw_pkg::ROW_W-1:0]  rows,
    input  logic [ttcw_pkg::CHAR_W-1:0] char_code,
    output ttcw_pkg::put_act_t          act
);
    import ttcw_pkg::*;

    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r0;
    logic [ROW_W-1:0] rows_m1;
    logic             last_row;
    logic             wrap;
    logic [COL_W:0]   tab_next;

    always_comb
    begin
        rows_m1  = rows - ROW_W'(1);
        c0       = (cur_col > cols) ? cols : cur_col;
        r0       = (cur_row >= rows) ? rows_m1 : cur_row;
        last_row = (r0 == rows_m1);
        wrap     = (c0 >= cols);
        tab_next = (COL_W+1)'((({1'b0, c0} / (COL_W+1)'(TAB_STOP)) + (COL_W+1)'(1))
                   * (COL_W+1)'(TAB_STOP));

        act         = '0;
        act.col     = c0;
        act.row     = r0;
        act.wr_char = char_code;

        priority if (char_code == CH_CR)
        begin
            act.col = '0;
        end
        else if (char_code == CH_LF)
        begin
            act.col    = '0;
            act.scroll = last_row;
            act.row    = last_row ? r0 : r0 + ROW_W'(1);
        end
        else if (char_code == CH_TAB)
        begin
            act.col = (tab_next >= {1'b0, cols}) ? cols - COL_W'(1) : tab_next[COL_W-1:0];
        end
        else if (char_code == CH_BS)
        begin
            if (c0 != '0)
            begin
                act.col = c0 - COL_W'(1);
            end
            else if (r0 != '0)
            begin
                act.row = r0 - ROW_W'(1);
                act.col = cols - COL_W'(1);
            end
            act.wr_en   = 1'b1;
            act.wr_col  = act.col;
            act.wr_row  = act.row;
            act.wr_char = CH_SPACE;
        end
        else if (char_code >= FIRST_PRINTABLE)
        begin
            act.wr_en  = 1'b1;
            act.scroll = wrap && last_row;
            act.wr_col = wrap ? '0 : c0;
            act.wr_row = (wrap && !last_row) ? r0 + ROW_W'(1) : r0;
            act.row    = act.wr_row;
            act.col    = act.wr_col + COL_W'(1);
        end
        else
        begin
        end
    end

endmodule

// ----- hdl/text_terminal_cell_writer_unit.sv -----
// Channel  Direction  Handshake            Transaction content
// in       input      in_valid / in_stall  op, char_code, read_column, read_row
// out      output     out_valid / out_stall cell_char, cursor_col_now, cursor_row_now, scrolled
// cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// A put without scroll, a read, and an unused op go from accept to ST_FIN, then to the registered result.
// A scroll copies each row up through the cell memory, one cell per cycle, in ST_MOVE (skipped with a single
// row), clears the bottom row in ST_LAST, and in ST_PUT stores the character if the put writes one.
// Clear and the pass after reset walk all MAX_COLUMNS*MAX_ROWS cells, one per cycle.
// The cell store is a single memory with one write and one registered read port.
// While a result waits on out_stall, the next transaction is still accepted.
module text_terminal_cell_writer_unit #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] char_code,
    input  logic [6:0] read_column,
    input  logic [5:0] read_row,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] cell_char,
    output logic [7:0] cursor_col_now,
    output logic [5:0] cursor_row_now,
    output logic       scrolled,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import ttcw_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [6:0] {
        ST_INIT = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_MOVE = 7'b0000100,
        ST_LAST = 7'b0001000,
        ST_PUT  = 7'b0010000,
        ST_WIPE = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
        cell_addr = AW'(32'(row) * MAX_COLUMNS + 32'(col));
    endfunction

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  num_columns_reg;
    logic [ROW_W-1:0]  num_rows_reg;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [ROW_W-1:0]  mv_row_reg, mv_row_next;
    logic [COL_W-1:0]  mv_col_reg, mv_col_next;
    logic              rd_active_reg, rd_active_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [AW-1:0]     wb_addr_reg, wb_addr_next;
    logic              put_wr_reg, put_wr_next;
    logic [COL_W-1:0]  put_col_reg, put_col_next;
    logic [ROW_W-1:0]  put_row_reg, put_row_next;
    logic [CHAR_W-1:0] put_char_reg, put_char_next;
    logic              cell_sel_reg, cell_sel_next;
    logic              scroll_reg, scroll_next;
    logic              out_valid_reg;
    logic [7:0]        cell_char_reg;
    logic [7:0]        out_col_reg;
    logic [5:0]        out_row_reg;
    logic              out_scroll_reg;

    logic [COL_W-1:0]  cols;
    logic [ROW_W-1:0]  rows;
    logic [ROW_W-1:0]  rows_m1;
    logic              accept;
    logic              read_in_range;
    logic              out_load;
    put_act_t          act;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;
    logic [ROW_W-1:0]  w_row;
    logic [COL_W-1:0]  w_col;
    logic              w_direct;

    always_comb
    begin
        if (num_columns_reg == '0)
        begin
            cols = COL_W'(1);
        end
        else if (32'(num_columns_reg) > MAX_COLUMNS)
        begin
            cols = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            cols = num_columns_reg;
        end
        if (num_rows_reg == '0)
        begin
            rows = ROW_W'(1);
        end
        else if (32'(num_rows_reg) > MAX_ROWS)
        begin
            rows = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows = num_rows_reg;
        end
        rows_m1 = rows - ROW_W'(1);
    end

    ttcw_cursor_step u_cursor_step (
        .cur_col   (cur_col_reg),
        .cur_row   (cur_row_reg),
        .cols      (cols),
        .rows      (rows),
        .char_code (char_code),
        .act       (act)
    );

    ttcw_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall      = (state_reg != ST_IDLE);
    assign accept        = in_valid && !in_stall;
    assign read_in_range = ({1'b0, read_column} < cols) && ({1'b0, read_row} < rows);
    assign out_load      = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        sweep_next     = sweep_reg;
        mv_row_next    = mv_row_reg;
        mv_col_next    = mv_col_reg;
        rd_active_next = rd_active_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        put_wr_next    = put_wr_reg;
        put_col_next   = put_col_reg;
        put_row_next   = put_row_reg;
        put_char_next  = put_char_reg;
        cell_sel_next  = cell_sel_reg;
        scroll_next    = scroll_reg;

        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = cell_addr(ROW_W'(read_row), COL_W'(read_column));
        w_direct  = 1'b0;
        w_row     = act.wr_row;
        w_col     = act.wr_col;

        unique case (state_reg)
            ST_INIT, ST_WIPE:
            begin
                mem_we     = 1'b1;
                w_direct   = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_FIN;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cell_sel_next = 1'b0;
                    scroll_next   = 1'b0;
                    state_next    = ST_FIN;
                    unique case (op_t'(op))
                        OP_PUT:
                        begin
                            cur_col_next  = act.col;
                            cur_row_next  = act.row;
                            scroll_next   = act.scroll;
                            put_wr_next   = act.wr_en;
                            put_col_next  = act.wr_col;
                            put_row_next  = act.wr_row;
                            put_char_next = act.wr_char;
                            if (act.scroll)
                            begin
                                mv_row_next    = '0;
                                mv_col_next    = '0;
                                rd_active_next = (rows != ROW_W'(1));
                                state_next     = (rows != ROW_W'(1)) ? ST_MOVE : ST_LAST;
                            end
                            else
                            begin
                                mem_we    = act.wr_en;
                                mem_wdata = act.wr_char;
                            end
                        end
                        OP_READ:
                        begin
                            mem_re        = read_in_range;
                            cell_sel_next = read_in_range;
                        end
                        OP_CLEAR:
                        begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                            sweep_next   = '0;
                            state_next   = ST_WIPE;
                        end
                        OP_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MOVE:
            begin
                if (rd_active_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = cell_addr(mv_row_reg + ROW_W'(1), mv_col_reg);
                    wb_valid_next = 1'b1;
                    wb_addr_next  = cell_addr(mv_row_reg, mv_col_reg);
                    if (mv_col_reg == cols - COL_W'(1))
                    begin
                        mv_col_next = '0;
                        mv_row_next = mv_row_reg + ROW_W'(1);
                        if (mv_row_reg + ROW_W'(1) == rows_m1)
                        begin
                            rd_active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        mv_col_next = mv_col_reg + COL_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_LAST;
                end
                if (wb_valid_reg)
                begin
                    mem_we    = 1'b1;
                    w_direct  = 1'b1;
                    mem_wdata = mem_rdata;
                end
            end
            ST_LAST:
            begin
                mem_we = 1'b1;
                w_row  = rows_m1;
                w_col  = mv_col_reg;
                if (mv_col_reg == cols - COL_W'(1))
                begin
                    state_next = put_wr_reg ? ST_PUT : ST_FIN;
                end
                else
                begin
                    mv_col_next = mv_col_reg + COL_W'(1);
                end
            end
            ST_PUT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = put_char_reg;
                w_row      = put_row_reg;
                w_col      = put_col_reg;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        if (w_direct)
        begin
            mem_waddr = (state_reg == ST_MOVE) ? wb_addr_reg : sweep_reg;
        end
        else
        begin
            mem_waddr = cell_addr(w_row, w_col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            num_columns_reg <= 8'd80;
            num_rows_reg    <= 7'd25;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            sweep_reg       <= '0;
            mv_row_reg      <= '0;
            mv_col_reg      <= '0;
            rd_active_reg   <= 1'b0;
            wb_valid_reg    <= 1'b0;
            put_wr_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            sweep_reg     <= sweep_next;
            mv_row_reg    <= mv_row_next;
            mv_col_reg    <= mv_col_next;
            rd_active_reg <= rd_active_next;
            wb_valid_reg  <= wb_valid_next;
            put_wr_reg    <= put_wr_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_NUM_COLUMNS: num_columns_reg <= cfg_data;
                    CFG_NUM_ROWS:    num_rows_reg    <= cfg_data[ROW_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg   <= wb_addr_next;
        put_col_reg   <= put_col_next;
        put_row_reg   <= put_row_next;
        put_char_reg  <= put_char_next;
        cell_sel_reg  <= cell_sel_next;
        scroll_reg    <= scroll_next;
        if (out_load)
        begin
            cell_char_reg  <= cell_sel_reg ? mem_rdata : 8'd0;
            out_col_reg    <= cur_col_reg;
            out_row_reg    <= cur_row_reg[5:0];
            out_scroll_reg <= scroll_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_char      = cell_char_reg;
    assign cursor_col_now = out_col_reg;
    assign cursor_row_now = out_row_reg;
    assign scrolled       = out_scroll_reg;

endmodule

// ----- hdl/ttcw_checker.sv -----
`include "text_terminal_cell_writer_unit_defines.svh"

module ttcw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] cell_char,
    input logic [7:0] cursor_col_now,
    input logic       scrolled
);

    // Each transaction is worked on alone, so the input stalls right after an accept.
    `TTCW_CHECK_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall)

    // A result held by the receiver keeps its content.
    `TTCW_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cell_char) && $stable(cursor_col_now))

    // A scroll leaves the cursor at the start of the bottom row or just after it.
    `TTCW_CHECK_NOW(a_scroll_col, out_valid && scrolled, cursor_col_now == 8'd0 || cursor_col_now == 8'd1)

endmodule

bind text_terminal_cell_writer_unit ttcw_checker u_ttcw_checker (.*);

// ----- tb/tb_text_terminal_cell_writer_unit.sv -----
module tb_text_terminal_cell_writer_unit;
    import ttcw_pkg::*;

    localparam int GRID_COLS = 128;
    localparam int GRID_ROWS = 64;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] col;
        logic [5:0] row;
        logic       scrolled;
    } cell_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] op = OP_NONE;
    logic [7:0] char_code = 8'h00;
    logic [6:0] read_column = 7'h00;
    logic [5:0] read_row = 6'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] cell_char;
    logic [7:0] cursor_col_now;
    logic [5:0] cursor_row_now;
    logic       scrolled;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_index = CFG_NUM_COLUMNS;
    logic [7:0] cfg_data = 8'h00;

    // Shadow copy of the terminal state used to predict each transaction.
    logic [7:0] screen_cells [GRID_COLS*GRID_ROWS];
    int         cur_col = 0;
    int         cur_row = 0;
    logic [7:0] reg_columns = 8'd80;
    logic [6:0] reg_rows = 7'd25;

    cell_result_t pending_results [$];
    int           mismatch_count = 0;
    bit           send_gaps = 1'b1;
    bit           stall_gaps = 1'b1;
    bit           idle_allowed = 1'b1;

    text_terminal_cell_writer_unit #(
        .MAX_COLUMNS(GRID_COLS),
        .MAX_ROWS   (GRID_ROWS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .char_code     (char_code),
        .read_column   (read_column),
        .read_row      (read_row),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_char     (cell_char),
        .cursor_col_now(cursor_col_now),
        .cursor_row_now(cursor_row_now),
        .scrolled      (scrolled),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int active_columns();
        if (reg_columns == 0)
            return 1;
        if (reg_columns > GRID_COLS)
            return GRID_COLS;
        return int'(reg_columns);
    endfunction

    function automatic int active_rows();
        if (reg_rows == 0)
            return 1;
        if (reg_rows > GRID_ROWS)
            return GRID_ROWS;
        return int'(reg_rows);
    endfunction

    task automatic scroll_grid(input int cols, input int rows);
        for (int r = 0; r + 1 < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
                screen_cells[r*GRID_COLS + c] = screen_cells[(r + 1)*GRID_COLS + c];
        end
        for (int c = 0; c < cols; c++)
            screen_cells[(rows - 1)*GRID_COLS + c] = 8'h00;
        if (cur_row > 0)
            cur_row--;
    endtask

    task automatic put_character(input logic [7:0] ch, output logic did_scroll);
        int cols;
        int rows;
        int next_stop;
        cols = active_columns();
        rows = active_rows();
        did_scroll = 1'b0;
        if (cur_row >= rows)
            cur_row = rows - 1;
        if (cur_col > cols)
            cur_col = cols;
        if (ch == CH_CR)
        begin
            cur_col = 0;
        end
        else if (ch == CH_LF)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= rows)
            begin
                scroll_grid(cols, rows);
                did_scroll = 1'b1;
            end
        end
        else if (ch == CH_TAB)
        begin
            next_stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
            cur_col = (next_stop >= cols) ? cols - 1 : next_stop;
        end
        else if (ch == CH_BS)
        begin
            if (cur_col > 0)
            begin
                cur_col--;
            end
            else if (cur_row > 0)
            begin
                cur_row--;
                cur_col = cols - 1;
            end
            if (cur_col >= cols)
                cur_col = cols - 1;
            screen_cells[cur_row*GRID_COLS + cur_col] = CH_SPACE;
        end
        else if (ch >= FIRST_PRINTABLE)
        begin
            if (cur_col >= cols)
            begin
                cur_col = 0;
                cur_row++;
                if (cur_row >= rows)
                begin
                    scroll_grid(cols, rows);
                    did_scroll = 1'b1;
                end
            end
            screen_cells[cur_row*GRID_COLS + cur_col] = ch;
            cur_col++;
        end
    endtask

    task automatic predict_result(input op_t kind, input logic [7:0] ch,
                                  input logic [6:0] rcol, input logic [5:0] rrow,
                                  output cell_result_t res);
        logic did_scroll;
        did_scroll = 1'b0;
        res.cell_char = 8'h00;
        case (kind)
            OP_PUT:
                put_character(ch, did_scroll);
            OP_READ:
            begin
                if (int'(rcol) < active_columns() && int'(rrow) < active_rows())
                    res.cell_char = screen_cells[int'(rrow)*GRID_COLS + int'(rcol)];
            end
            OP_CLEAR:
            begin
                foreach (screen_cells[i])
                    screen_cells[i] = 8'h00;
                cur_col = 0;
                cur_row = 0;
            end
            default:
            begin
            end
        endcase
        res.col = cur_col[7:0];
        res.row = cur_row[5:0];
        res.scrolled = did_scroll;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Called at a falling edge; drops the valid after acceptance and returns in the cycle after that.
    task automatic send_item(input op_t kind, input logic [7:0] ch,
                             input logic [6:0] rcol, input logic [5:0] rrow);
        cell_result_t res;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= kind;
        char_code   <= ch;
        read_column <= rcol;
        read_row    <= rrow;
        do
            @(posedge clk);
        while (in_stall);
        predict_result(kind, ch, rcol, rrow, res);
        pending_results.push_back(res);
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic put_byte(input logic [7:0] ch);
        send_item(OP_PUT, ch, 7'($urandom), 6'($urandom));
    endtask

    task automatic read_cell(input logic [6:0] rcol, input logic [5:0] rrow);
        send_item(OP_READ, 8'($urandom), rcol, rrow);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == CFG_NUM_COLUMNS)
            reg_columns = data;
        else
            reg_rows = data[6:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(input logic [7:0] col_data, input logic [7:0] row_data);
        drain_results();
        write_register(CFG_NUM_COLUMNS, col_data);
        write_register(CFG_NUM_ROWS, row_data);
    endtask

    function automatic logic [7:0] random_char(input int lf_weight);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < lf_weight)
            return CH_LF;
        pick = $urandom_range(0, 89);
        if (pick < 5)
            return CH_CR;
        else if (pick < 13)
            return CH_TAB;
        else if (pick < 23)
            return CH_BS;
        else if (pick < 28)
            return 8'($urandom_range(0, 31));
        else if (pick < 70)
            return 8'($urandom_range(32, 126));
        return 8'($urandom_range(127, 255));
    endfunction

    task automatic random_item(input int lf_weight);
        int pick;
        int col_lim;
        int row_lim;
        pick = $urandom_range(0, 199);
        col_lim = (active_columns() + 1 > 127) ? 127 : active_columns() + 1;
        row_lim = (active_rows() + 1 > 63) ? 63 : active_rows() + 1;
        if (pick < 2)
            send_item(OP_CLEAR, 8'($urandom), 7'($urandom), 6'($urandom));
        else if (pick < 8)
            send_item(OP_NONE, 8'($urandom), 7'($urandom), 6'($urandom));
        else if (pick < 60)
        begin
            if ($urandom_range(0, 3) == 0)
                read_cell(7'($urandom), 6'($urandom));
            else
                read_cell(7'($urandom_range(0, col_lim)), 6'($urandom_range(0, row_lim)));
        end
        else
            put_byte(random_char(lf_weight));
    endtask

    function automatic logic [7:0] pick_dimension(input int max_value, input int cap);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 8'd0;
        else if (pick == 1)
            return 8'd1;
        else if (pick < 5)
            return 8'($urandom_range(1, cap));
        return 8'($urandom_range(1, max_value));
    endfunction

    task automatic run_random_phase(input int items, input logic [7:0] col_data,
                                    input logic [7:0] row_data, input int lf_weight);
        set_geometry(col_data, row_data);
        send_gaps = idle_allowed && ($urandom_range(0, 2) != 0);
        stall_gaps = idle_allowed && ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 2) == 0)
            send_item(OP_CLEAR, 8'($urandom), 7'($urandom), 6'($urandom));
        repeat (items) random_item(lf_weight);
    endtask

    task automatic test_put_controls();
        put_byte(8'h41);
        put_byte(8'h7F);
        put_byte(8'h80);
        put_byte(8'hFF);
        put_byte(CH_TAB);
        put_byte(CH_BS);
        put_byte(CH_CR);
        put_byte(8'h00);
        put_byte(8'h1F);
        put_byte(CH_LF);
    endtask

    task automatic test_read_and_unused();
        read_cell(7'd0, 6'd0);
        read_cell(7'd127, 6'd63);
        send_item(OP_NONE, 8'hFF, 7'h7F, 6'h3F);
    endtask

    // A zero in either register behaves as one column or row.
    task automatic test_minimal_grid();
        set_geometry(8'd0, 8'd0);
        put_byte(8'h78);
        put_byte(8'h79);
        read_cell(7'd0, 6'd0);
    endtask

    task automatic test_tab_and_backspace();
        set_geometry(8'd10, 8'd2);
        put_byte(CH_TAB);
        put_byte(CH_TAB);
        put_byte(8'h7A);
        put_byte(CH_BS);
        put_byte(CH_LF);
        put_byte(CH_BS);
        put_byte(CH_LF);
        put_byte(CH_LF);
    endtask

    // The cursor sits below the new last row until the next put clamps it.
    task automatic test_geometry_change();
        drain_results();
        write_register(CFG_NUM_ROWS, 8'd1);
        put_byte(8'h71);
        read_cell(7'd0, 6'd1);
    endtask

    task automatic test_clear();
        send_item(OP_CLEAR, 8'h00, 7'h00, 6'h00);
    endtask

    task automatic test_random_small();
        repeat (12) run_random_phase(60, pick_dimension(16, 40), pick_dimension(8, 16), 10);
    endtask

    task automatic test_random_large();
        run_random_phase(30, 8'd128, 8'd64, 2);
        run_random_phase(30, 8'hFF, 8'hC0, 2);
    endtask

    task automatic test_random_steady();
        run_random_phase(50, pick_dimension(16, 32), pick_dimension(8, 16), 10);
        idle_allowed = 1'b0;
        repeat (2)
            run_random_phase(50, pick_dimension(16, 32), pick_dimension(8, 16), 10);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_gaps && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no pending transaction", int'(cell_char), -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (cell_char !== want.cell_char)
                    report_mismatch("cell_char", int'(cell_char), int'(want.cell_char));
                if (cursor_col_now !== want.col)
                    report_mismatch("cursor_col_now", int'(cursor_col_now), int'(want.col));
                if (cursor_row_now !== want.row)
                    report_mismatch("cursor_row_now", int'(cursor_row_now), int'(want.row));
                if (scrolled !== want.scrolled)
                    report_mismatch("scrolled", int'(scrolled), int'(want.scrolled));
            end
        end
    end

    initial
    begin
        foreach (screen_cells[i])
            screen_cells[i] = 8'h00;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_put_controls();
        test_read_and_unused();
        test_minimal_grid();
        test_tab_and_backspace();
        test_geometry_change();
        test_clear();
        test_random_small();
        test_random_large();
        test_random_steady();

        drain_results();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("Verification failed");
        $finish;
    end

endmodule
